// ----- sv/top_k_selector_top_defines.svh -----
// ----------------------------------------------------------------------------
// Top-k selector assertion macros
// Shared property forms for the concurrent checks of the selector.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// Top-k selector package
// Sizes, register indexes, shared types and the key ordering function.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 48;
  localparam int KEY_W    = 64;
  localparam int LIM_W    = 7;
  localparam int ENTRY_W  = ID_W + KEY_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic REG_KEEP_LIMIT = 1'b0;
  localparam logic REG_ASCENDING  = 1'b1;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [LIM_W-1:0] keep_limit;
    logic             ascending;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } stat_t;

  typedef struct packed {
    logic [ID_W-1:0]  node_id;
    logic [KEY_W-1:0] key;
  } entry_t;

  // True when key a must be placed strictly before key b.
  function automatic logic better(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                  input logic ascending);
    logic signed [KEY_W-1:0] sa;
    logic signed [KEY_W-1:0] sb;
    sa = a;
    sb = b;
    return ascending ? (sa < sb) : (sa > sb);
  endfunction

endpackage

// ----- sv/tks_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tks_ctrl.sv -----
// ----------------------------------------------------------------------------
// Top-k selector sequencer
// Inserts offers into the sorted store and streams it out on a flush.
// ----------------------------------------------------------------------------
module tks_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tks_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [tks_pkg::ID_W-1:0]  node_id_i,
  input  logic [tks_pkg::KEY_W-1:0] sort_key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tks_pkg::ID_W-1:0]  out_node_id_o,
  output logic [tks_pkg::KEY_W-1:0] out_key_o,
  output logic                      last_o,
  output tks_pkg::stat_t            stat_o,
  output logic                      we_o,
  output logic [tks_pkg::IDX_W-1:0] waddr_o,
  output tks_pkg::entry_t           wdata_o,
  output logic [tks_pkg::IDX_W-1:0] raddr_o,
  input  tks_pkg::entry_t           rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_FL_RD,
    ST_FL_CAP
  } state_e;

  state_e                      state_q;
  logic [tks_pkg::CNT_W-1:0]   cnt_q;
  logic [tks_pkg::CNT_W-1:0]   new_cnt_q;
  logic [tks_pkg::IDX_W-1:0]   idx_q;
  logic [tks_pkg::IDX_W-1:0]   last_idx_q;
  tks_pkg::entry_t             new_q;
  logic                        oval_q;
  tks_pkg::entry_t             out_q;
  logic                        olast_q;

  logic [tks_pkg::CNT_W-1:0]   lim;
  logic [tks_pkg::CNT_W-1:0]   cnt_clamp;
  logic                        accept;
  logic                        hit;
  logic                        slot_free;

  assign lim = (cfg_i.keep_limit > tks_pkg::LIM_W'(tks_pkg::CAPACITY))
             ? tks_pkg::CNT_W'(tks_pkg::CAPACITY)
             : tks_pkg::CNT_W'(cfg_i.keep_limit);
  assign cnt_clamp = (cnt_q > lim) ? lim : cnt_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign hit = tks_pkg::better(new_q.key, rdata_i.key, cfg_i.ascending);
  assign slot_free = !oval_q || out_ready_i;

  always_comb begin
    we_o = 1'b0;
    waddr_o = idx_q;
    wdata_o = new_q;
    raddr_o = idx_q;
    case (state_q)
      ST_INS_RD: begin
        raddr_o = idx_q - tks_pkg::IDX_W'(1);
        if (idx_q == '0) begin
          we_o = 1'b1;
        end
      end
      ST_INS_CMP: begin
        we_o = 1'b1;
        if (hit) begin
          wdata_o = rdata_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      new_cnt_q  <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
      new_q      <= '0;
      oval_q     <= 1'b0;
      out_q      <= '0;
      olast_q    <= 1'b0;
    end else begin
      if (oval_q && out_ready_i) begin
        oval_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            new_q.node_id <= node_id_i;
            new_q.key     <= sort_key_i;
            if (kind_i == tks_pkg::KIND_OFFER) begin
              cnt_q <= cnt_clamp;
              if (lim == '0) begin
                state_q <= ST_IDLE;
              end else if (cnt_clamp < lim) begin
                idx_q     <= tks_pkg::IDX_W'(cnt_clamp);
                new_cnt_q <= cnt_clamp + tks_pkg::CNT_W'(1);
                state_q   <= ST_INS_RD;
              end else begin
                idx_q     <= tks_pkg::IDX_W'(lim - tks_pkg::CNT_W'(1));
                new_cnt_q <= lim;
                state_q   <= ST_CHK_RD;
              end
            end else begin
              if (cnt_clamp == '0) begin
                cnt_q <= '0;
              end else begin
                idx_q      <= '0;
                last_idx_q <= tks_pkg::IDX_W'(cnt_clamp - tks_pkg::CNT_W'(1));
                state_q    <= ST_FL_RD;
              end
            end
          end
        end
        ST_CHK_RD: begin
          state_q <= ST_CHK_CMP;
        end
        ST_CHK_CMP: begin
          state_q <= hit ? ST_INS_RD : ST_IDLE;
        end
        ST_INS_RD: begin
          if (idx_q == '0) begin
            cnt_q   <= new_cnt_q;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (hit) begin
            idx_q   <= idx_q - tks_pkg::IDX_W'(1);
            state_q <= ST_INS_RD;
          end else begin
            cnt_q   <= new_cnt_q;
            state_q <= ST_IDLE;
          end
        end
        ST_FL_RD: begin
          if (slot_free) begin
            state_q <= ST_FL_CAP;
          end
        end
        ST_FL_CAP: begin
          oval_q  <= 1'b1;
          out_q   <= rdata_i;
          olast_q <= (idx_q == last_idx_q);
          if (idx_q == last_idx_q) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + tks_pkg::IDX_W'(1);
            state_q <= ST_FL_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = oval_q;
  assign out_node_id_o = out_q.node_id;
  assign out_key_o     = out_q.key;
  assign last_o        = olast_q;
  assign stat_o.busy   = (state_q != ST_IDLE);
  assign stat_o.count  = cnt_q;

endmodule

// ----- sv/top_k_selector_top.sv -----
// ----------------------------------------------------------------------------
// Top-k selector
// Keeps the best entries of a candidate stream and flushes them in order.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid_i/in_ready_o. kind_i low offers a candidate
// (node_id_i, sort_key_i); kind_i high flushes the kept entries. Results leave
// on out_valid_o/out_ready_i, one item per kept entry, best first, with
// last_o on the final one. The APB port sets keep_limit and ascending_order
// and must only be written while the block is idle.
// The kept entries live sorted in one RAM with a registered read.
// An offer is taken in the idle state. When the store is full, the worst
// entry is read and compared first; an offer not strictly better, or any
// offer while keep_limit is 0, is dropped. A kept offer walks up the store
// with a read and a compare per entry it moves past, then is written in
// place. A flush reads and sends the kept entries one at a time.
// A stalled receiver holds the flush with the pending item in the output
// register; offers are still taken while an item waits there.
// Reset empties the store, sets keep_limit to 16 and ascending_order to 1.
// ----------------------------------------------------------------------------
`include "top_k_selector_top_defines.svh"

module top_k_selector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]  paddr,
  input  logic [tks_pkg::DATA_W-1:0]  pwdata,
  output logic [tks_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [tks_pkg::ID_W-1:0]    node_id_i,
  input  logic signed [tks_pkg::KEY_W-1:0] sort_key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tks_pkg::ID_W-1:0]    out_node_id_o,
  output logic signed [tks_pkg::KEY_W-1:0] out_key_o,
  output logic                        last_o
);

  tks_pkg::cfg_t             cfg_q;
  tks_pkg::stat_t            stat;
  logic                      we;
  logic [tks_pkg::IDX_W-1:0] waddr;
  logic [tks_pkg::IDX_W-1:0] raddr;
  tks_pkg::entry_t           wdata;
  tks_pkg::entry_t           rdata;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_limit <= tks_pkg::LIM_W'(16);
      cfg_q.ascending  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        tks_pkg::REG_KEEP_LIMIT: cfg_q.keep_limit <= pwdata[tks_pkg::LIM_W-1:0];
        tks_pkg::REG_ASCENDING:  cfg_q.ascending  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tks_pkg::REG_KEEP_LIMIT: prdata = tks_pkg::DATA_W'(cfg_q.keep_limit);
      tks_pkg::REG_ASCENDING:  prdata = tks_pkg::DATA_W'(cfg_q.ascending);
      default:                 prdata = '0;
    endcase
  end

  tks_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .node_id_i     (node_id_i),
    .sort_key_i    (sort_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_node_id_o (out_node_id_o),
    .out_key_o     (out_key_o),
    .last_o        (last_o),
    .stat_o        (stat),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  tks_ram #(
    .WIDTH (tks_pkg::ENTRY_W),
    .DEPTH (tks_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  `TKS_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= tks_pkg::CNT_W'(tks_pkg::CAPACITY), "kept count above capacity")
  `TKS_ASSERT_NXT(a_offer_silent, in_valid_i && in_ready_o && !kind_i && !out_valid_o, !out_valid_o, "offer produced an item")
  `TKS_ASSERT_IMP(a_ready_idle, in_ready_o, !stat.busy, "input ready while sequencer busy")

endmodule
